// ----- design/ahhc_pkg.sv -----
// ----------------------------------------------------------------------------
// ahhc_pkg
// Shared types and constants for the automatic headlamp hysteresis control.
// ----------------------------------------------------------------------------
package ahhc_pkg;

    // Widths of the item fields and of the configuration registers.
    localparam int LUX_W     = 19;
    localparam int THR_W     = 18;
    localparam int DEB_W     = 8;
    localparam int SPEED_W   = 9;
    localparam int TIMEOUT_W = 20;
    localparam int ELAPSED_W = 16;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 20;

    // Mode codes; the fourth code is not a mode and a request for it is ignored.
    localparam logic [MODE_W-1:0] MODE_AUTO = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ON   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OFF  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DARK_ON     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT_OFF  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEED   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LUX     = 3'd5;

    // Reset values of the configuration registers.
    localparam logic [THR_W-1:0]     RST_DARK_ON    = 18'd300;
    localparam logic [THR_W-1:0]     RST_BRIGHT_OFF = 18'd500;
    localparam logic [DEB_W-1:0]     RST_DEBOUNCE   = 8'd3;
    localparam logic [SPEED_W-1:0]   RST_MIN_SPEED  = 9'd10;
    localparam logic [TIMEOUT_W-1:0] RST_TIMEOUT    = 20'd120000;
    localparam logic [THR_W-1:0]     RST_MAX_LUX    = 18'd200000;

    typedef struct packed {
        logic [THR_W-1:0]     dark_on_threshold;
        logic [THR_W-1:0]     bright_off_threshold;
        logic [DEB_W-1:0]     debounce_samples;
        logic [SPEED_W-1:0]   min_speed;
        logic [TIMEOUT_W-1:0] override_timeout;
        logic [THR_W-1:0]     max_valid_lux;
    } t_cfg;

    typedef struct packed {
        logic                    override_request;
        logic [MODE_W-1:0]       requested_mode;
        logic [ELAPSED_W-1:0]    tick_ms;
        logic signed [LUX_W-1:0] light_lux;
        logic                    tunnel_flag;
        logic [SPEED_W-1:0]      speed_kph;
    } t_item;

    typedef struct packed {
        logic                 lamp_state;
        logic                 sensor_fault;
        logic [MODE_W-1:0]    mode_now;
        logic [TIMEOUT_W-1:0] override_left_ms;
    } t_result;

endpackage

// ----- design/ahhc_in_stage.sv -----
// ----------------------------------------------------------------------------
// ahhc_in_stage
// Input register: captures one item and holds it until the update takes it.
// ----------------------------------------------------------------------------
module ahhc_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  logic           i_take,
    input  ahhc_pkg::t_item i_item,
    output logic           o_valid,
    output ahhc_pkg::t_item o_item
);
    import ahhc_pkg::*;

    logic  r_valid;
    t_item r_item;

    // Valid flag: set on a new item, cleared when the item moves on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // Payload capture.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ----- design/ahhc_update.sv -----
// ----------------------------------------------------------------------------
// ahhc_update
// Controller state and its one-pass update for each tick item.
// ----------------------------------------------------------------------------
module ahhc_update #(
    parameter int RUN_COUNTER_BITS = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  ahhc_pkg::t_cfg   i_cfg,
    input  ahhc_pkg::t_item  i_item,
    output ahhc_pkg::t_result o_result
);
    import ahhc_pkg::*;

    localparam int CMP_W = (RUN_COUNTER_BITS > DEB_W) ? RUN_COUNTER_BITS : DEB_W;
    localparam logic [RUN_COUNTER_BITS-1:0] RUN_MAX = '1;

    logic                        r_lamp, n_lamp;
    logic                        r_fault, n_fault;
    logic [MODE_W-1:0]           r_mode, n_mode;
    logic [TIMEOUT_W-1:0]        r_countdown, n_countdown;
    logic [RUN_COUNTER_BITS-1:0] r_dark_run, n_dark_run;
    logic [RUN_COUNTER_BITS-1:0] r_bright_run, n_bright_run;

    logic                        negative;
    logic [THR_W-1:0]            lux;
    logic [TIMEOUT_W-1:0]        elapsed_ext;
    logic [RUN_COUNTER_BITS-1:0] dark_inc;
    logic [RUN_COUNTER_BITS-1:0] bright_inc;

    assign negative    = i_item.light_lux[LUX_W-1];
    assign lux         = i_item.light_lux[THR_W-1:0];
    assign elapsed_ext = TIMEOUT_W'(i_item.tick_ms);
    assign dark_inc    = (r_dark_run == RUN_MAX) ? RUN_MAX : r_dark_run + 1'b1;
    assign bright_inc  = (r_bright_run == RUN_MAX) ? RUN_MAX : r_bright_run + 1'b1;

    // Mode and override countdown.
    always_comb begin
        n_mode      = r_mode;
        n_countdown = r_countdown;
        if (i_item.override_request && i_item.requested_mode != MODE_NONE) begin
            n_mode      = i_item.requested_mode;
            n_countdown = (i_item.requested_mode == MODE_AUTO) ? '0 : i_cfg.override_timeout;
        end else if (!i_item.override_request && r_mode != MODE_AUTO) begin
            if (elapsed_ext >= r_countdown) begin
                n_mode      = MODE_AUTO;
                n_countdown = '0;
            end else begin
                n_countdown = r_countdown - elapsed_ext;
            end
        end
    end

    // Fault check, lamp decision and debounce counters.
    always_comb begin
        n_lamp       = r_lamp;
        n_fault      = r_fault;
        n_dark_run   = r_dark_run;
        n_bright_run = r_bright_run;
        if (negative || lux > i_cfg.max_valid_lux) begin
            n_fault = 1'b1;
        end else begin
            n_fault = 1'b0;
            priority if (n_mode == MODE_ON) begin
                n_lamp = 1'b1;
            end else if (n_mode == MODE_OFF) begin
                n_lamp = 1'b0;
            end else if (i_item.tunnel_flag) begin
                n_lamp       = 1'b1;
                n_dark_run   = '0;
                n_bright_run = '0;
            end else if (i_item.speed_kph < i_cfg.min_speed) begin
                n_lamp       = 1'b0;
                n_dark_run   = '0;
                n_bright_run = '0;
            end else if (lux <= i_cfg.dark_on_threshold) begin
                n_dark_run   = dark_inc;
                n_bright_run = '0;
                if (CMP_W'(dark_inc) >= CMP_W'(i_cfg.debounce_samples)) begin
                    n_lamp = 1'b1;
                end
            end else if (lux >= i_cfg.bright_off_threshold) begin
                n_bright_run = bright_inc;
                n_dark_run   = '0;
                if (CMP_W'(bright_inc) >= CMP_W'(i_cfg.debounce_samples)) begin
                    n_lamp = 1'b0;
                end
            end else begin
                n_dark_run   = '0;
                n_bright_run = '0;
            end
        end
    end

    // State registers advance once per item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lamp       <= 1'b0;
            r_fault      <= 1'b0;
            r_mode       <= MODE_AUTO;
            r_countdown  <= '0;
            r_dark_run   <= '0;
            r_bright_run <= '0;
        end else if (i_fire) begin
            r_lamp       <= n_lamp;
            r_fault      <= n_fault;
            r_mode       <= n_mode;
            r_countdown  <= n_countdown;
            r_dark_run   <= n_dark_run;
            r_bright_run <= n_bright_run;
        end
    end

    // The result reports the state after the update.
    assign o_result.lamp_state       = n_lamp;
    assign o_result.sensor_fault     = n_fault;
    assign o_result.mode_now         = n_mode;
    assign o_result.override_left_ms = n_countdown;

endmodule

// ----- design/ahhc_out_stage.sv -----
// ----------------------------------------------------------------------------
// ahhc_out_stage
// Result register: holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module ahhc_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  logic              i_fire,
    input  ahhc_pkg::t_result i_result,
    output logic              o_valid,
    output ahhc_pkg::t_result o_result
);
    import ahhc_pkg::*;

    logic    r_valid;
    t_result r_result;

    // Valid flag follows the update whenever the register is free to move.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= i_fire;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ----- design/auto_headlamp_hysteresis_control.sv -----
// ----------------------------------------------------------------------------
// auto_headlamp_hysteresis_control
// Automatic headlamp control with light hysteresis, debounce and override.
// ----------------------------------------------------------------------------
// Each input item is one update tick: override request, requested mode,
// elapsed milliseconds, ambient lux, tunnel flag and speed. Each item gives
// exactly one result item: lamp state, sensor fault, active mode and the
// milliseconds left in a manual override, all as they stand after the tick.
// Both channels use valid and stall; an item moves at a clock edge where
// valid is high and stall is low. The user must write the configuration
// registers through i_cfg_we, i_cfg_index and i_cfg_data while the block
// is idle; the block itself does not enforce this. A result is offered once
// the update has moved its item from the input register into the result
// register. Throughput: one item per cycle unless the receiver stalls; the
// whole update is one pass of compare and counter logic between the input
// register and the result register. When the receiver stalls, the result
// register holds its item, and the input stalls once its register is full.
// A synchronous reset clears both registers' valid flags, the controller
// state (lamp off, no fault, auto mode, counters zero) and loads the
// configuration registers with their default values.
// ----------------------------------------------------------------------------
module auto_headlamp_hysteresis_control #(
    parameter int RUN_COUNTER_BITS = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Configuration write port.
    input  logic                                  i_cfg_we,
    input  logic [ahhc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [ahhc_pkg::CFG_DAT_W-1:0]        i_cfg_data,
    // Input channel.
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_override_request,
    input  logic [ahhc_pkg::MODE_W-1:0]           i_requested_mode,
    input  logic [ahhc_pkg::ELAPSED_W-1:0]        i_tick_ms,
    input  logic signed [ahhc_pkg::LUX_W-1:0]     i_light_lux,
    input  logic                                  i_tunnel_flag,
    input  logic [ahhc_pkg::SPEED_W-1:0]          i_speed_kph,
    // Output channel.
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic                                  o_lamp_state,
    output logic                                  o_sensor_fault,
    output logic [ahhc_pkg::MODE_W-1:0]           o_mode_now,
    output logic [ahhc_pkg::TIMEOUT_W-1:0]        o_override_left_ms
);
    import ahhc_pkg::*;

    t_cfg    r_cfg;
    t_item   in_item;
    t_item   held_item;
    t_result upd_result;
    t_result out_result;
    logic    held_valid;
    logic    advance;
    logic    fire;
    logic    in_load;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dark_on_threshold    <= RST_DARK_ON;
            r_cfg.bright_off_threshold <= RST_BRIGHT_OFF;
            r_cfg.debounce_samples     <= RST_DEBOUNCE;
            r_cfg.min_speed            <= RST_MIN_SPEED;
            r_cfg.override_timeout     <= RST_TIMEOUT;
            r_cfg.max_valid_lux        <= RST_MAX_LUX;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DARK_ON:    r_cfg.dark_on_threshold    <= i_cfg_data[THR_W-1:0];
                CFG_BRIGHT_OFF: r_cfg.bright_off_threshold <= i_cfg_data[THR_W-1:0];
                CFG_DEBOUNCE:   r_cfg.debounce_samples     <= i_cfg_data[DEB_W-1:0];
                CFG_MIN_SPEED:  r_cfg.min_speed            <= i_cfg_data[SPEED_W-1:0];
                CFG_TIMEOUT:    r_cfg.override_timeout     <= i_cfg_data[TIMEOUT_W-1:0];
                CFG_MAX_LUX:    r_cfg.max_valid_lux        <= i_cfg_data[THR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Handshake: the held item moves on whenever the result register is free.
    assign advance    = !o_out_valid || !i_out_stall;
    assign fire       = held_valid && advance;
    assign o_in_stall = held_valid && !advance;
    assign in_load    = i_in_valid && !o_in_stall;

    assign in_item.override_request = i_override_request;
    assign in_item.requested_mode   = i_requested_mode;
    assign in_item.tick_ms          = i_tick_ms;
    assign in_item.light_lux        = i_light_lux;
    assign in_item.tunnel_flag      = i_tunnel_flag;
    assign in_item.speed_kph        = i_speed_kph;

    ahhc_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (in_load),
        .i_take  (fire),
        .i_item  (in_item),
        .o_valid (held_valid),
        .o_item  (held_item)
    );

    ahhc_update #(
        .RUN_COUNTER_BITS (RUN_COUNTER_BITS)
    ) u_update (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_cfg    (r_cfg),
        .i_item   (held_item),
        .o_result (upd_result)
    );

    ahhc_out_stage u_out_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_fire    (fire),
        .i_result  (upd_result),
        .o_valid   (o_out_valid),
        .o_result  (out_result)
    );

    assign o_lamp_state       = out_result.lamp_state;
    assign o_sensor_fault     = out_result.sensor_fault;
    assign o_mode_now         = out_result.mode_now;
    assign o_override_left_ms = out_result.override_left_ms;

endmodule
